// File: hdl/ubx_nav_pkg.sv
package ubx_nav_pkg;

  localparam int STORE_BYTES_DEF = 64;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd181;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd98;
  localparam logic [7:0] CLASS_RST       = 8'd1;
  localparam logic [7:0] MSG_ID_RST      = 8'd6;

  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_CLASS       = 2'd2,
    REG_MSG_ID      = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_SYNC1 = 4'd1,
    PH_SYNC2 = 4'd2,
    PH_ID    = 4'd3,
    PH_LEN1  = 4'd4,
    PH_LEN2  = 4'd5,
    PH_FILL  = 4'd6,
    PH_CKA   = 4'd7,
    PH_CKB   = 4'd8
  } phase_t;

  typedef struct packed {
    logic       write_enable;
    logic [5:0] write_offset;
    logic [7:0] write_data;
    logic       frame_good;
    logic       frame_error;
    logic       frame_ready;
  } result_t;

endpackage

// File: hdl/ubx_nav_frame_parser.sv
// UBX frame parser with 8-bit Fletcher checksum.
// Input channel (in_valid/in_stall): kind selects a received byte (0) or a
// release of the stored frame (1); data carries the byte.
// Output channel (out_valid/out_stall): one result per request, giving a
// store write (write_enable/offset/data), frame_good, frame_error and the
// ready flag after the request.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): sync bytes,
// accepted class and wanted id; always ready, write only while idle.
// Throughput: one request per cycle while the output is not stalled; the
// parser state update is a single compare/add step per byte and the result
// goes into an output register.
// A stalled receiver is absorbed by a one-entry skid register: one more
// request is taken while a result waits, then in_stall rises until the
// output drains.
// Reset (rst, synchronous) restores the register defaults, puts the parser
// in sync hunt, clears the ready flag and empties both output registers.
module ubx_nav_frame_parser
  import ubx_nav_pkg::*;
#(
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       write_enable,
  output logic [5:0] write_offset,
  output logic [7:0] write_data,
  output logic       frame_good,
  output logic       frame_error,
  output logic       frame_ready,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int PTR_W = $clog2(STORE_BYTES + 1);
  localparam logic [PTR_W-1:0] PTR_LIMIT = PTR_W'(STORE_BYTES);

  logic [7:0] sync_first, sync_second, accepted_class, wanted_id;

  phase_t      phase, phase_next;
  logic [7:0]  sum_a, sum_a_next, sum_b, sum_b_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [PTR_W-1:0] store_ptr, store_ptr_next;
  logic        frame_wanted, frame_wanted_next;
  logic        skip_store, skip_store_next;
  logic        ready_flag, ready_flag_next;

  result_t res_next, out_res, skid_res;
  logic    skid_valid;
  logic    accept, pop;
  logic [7:0] id_a, len_a, fill_a;
  logic [PTR_W+5:0] ptr_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first     <= SYNC_FIRST_RST;
      sync_second    <= SYNC_SECOND_RST;
      accepted_class <= CLASS_RST;
      wanted_id      <= MSG_ID_RST;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_SYNC_FIRST:  sync_first     <= cfg_data;
        REG_SYNC_SECOND: sync_second    <= cfg_data;
        REG_CLASS:       accepted_class <= cfg_data;
        REG_MSG_ID:      wanted_id      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign id_a    = accepted_class + data;
  assign len_a   = sum_a + data;
  assign fill_a  = sum_a + data;
  assign ptr_ext = {6'd0, store_ptr};

  always_comb begin
    phase_next        = phase;
    sum_a_next        = sum_a;
    sum_b_next        = sum_b;
    bytes_left_next   = bytes_left;
    store_ptr_next    = store_ptr;
    frame_wanted_next = frame_wanted;
    skip_store_next   = skip_store;
    ready_flag_next   = ready_flag;
    res_next          = '0;
    if (kind) begin
      ready_flag_next = 1'b0;
    end else begin
      case (phase)
        PH_HUNT: begin
          if (data == sync_first) phase_next = PH_SYNC1;
        end
        PH_SYNC1: begin
          if (data == sync_second) phase_next = PH_SYNC2;
          else if (data != sync_first) phase_next = PH_HUNT;
        end
        PH_SYNC2: begin
          phase_next = (data == accepted_class) ? PH_ID : PH_HUNT;
        end
        PH_ID: begin
          sum_a_next        = id_a;
          sum_b_next        = accepted_class + id_a;
          frame_wanted_next = (data == wanted_id);
          skip_store_next   = (data != wanted_id) || ready_flag;
          store_ptr_next    = '0;
          phase_next        = PH_LEN1;
        end
        PH_LEN1: begin
          bytes_left_next = {8'd0, data};
          sum_a_next      = len_a;
          sum_b_next      = sum_b + len_a;
          phase_next      = PH_LEN2;
        end
        PH_LEN2: begin
          bytes_left_next = {data, bytes_left[7:0]};
          sum_a_next      = len_a;
          sum_b_next      = sum_b + len_a;
          phase_next      = ({data, bytes_left[7:0]} == 16'd0) ? PH_CKA : PH_FILL;
        end
        PH_FILL: begin
          sum_a_next = fill_a;
          sum_b_next = sum_b + fill_a;
          if (!skip_store && store_ptr < PTR_LIMIT) begin
            res_next.write_enable = 1'b1;
            res_next.write_offset = ptr_ext[5:0];
            res_next.write_data   = data;
            store_ptr_next        = store_ptr + 1'b1;
          end
          bytes_left_next = bytes_left - 16'd1;
          if (bytes_left == 16'd1) phase_next = PH_CKA;
        end
        PH_CKA: begin
          if (data == sum_a) begin
            phase_next = PH_CKB;
          end else begin
            res_next.frame_error = 1'b1;
            phase_next           = PH_HUNT;
          end
        end
        PH_CKB: begin
          if (data == sum_b) begin
            if (frame_wanted && !skip_store) begin
              res_next.frame_good = 1'b1;
              ready_flag_next     = 1'b1;
            end
          end else begin
            res_next.frame_error = 1'b1;
          end
          phase_next = PH_HUNT;
        end
        default: phase_next = PH_HUNT;
      endcase
    end
    res_next.frame_ready = ready_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      sum_a        <= '0;
      sum_b        <= '0;
      bytes_left   <= '0;
      store_ptr    <= '0;
      frame_wanted <= 1'b0;
      skip_store   <= 1'b1;
      ready_flag   <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      sum_a        <= sum_a_next;
      sum_b        <= sum_b_next;
      bytes_left   <= bytes_left_next;
      store_ptr    <= store_ptr_next;
      frame_wanted <= frame_wanted_next;
      skip_store   <= skip_store_next;
      ready_flag   <= ready_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) out_res <= skid_res;
      else if (accept) out_res <= res_next;
    end else if (accept) begin
      skid_res <= res_next;
    end
  end

  assign write_enable = out_res.write_enable;
  assign write_offset = out_res.write_offset;
  assign write_data   = out_res.write_data;
  assign frame_good   = out_res.frame_good;
  assign frame_error  = out_res.frame_error;
  assign frame_ready  = out_res.frame_ready;

endmodule

// File: hdl/ubx_nav_checker.sv
module ubx_nav_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       write_enable,
  input logic [5:0] write_offset,
  input logic [7:0] write_data,
  input logic       frame_good,
  input logic       frame_error,
  input logic       frame_ready
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_good_sets_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_good |-> frame_ready && !frame_error && !write_enable)
    else $error("good frame without ready flag or with error/write");

  a_idle_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> write_offset == 6'd0 && write_data == 8'd0)
    else $error("write fields set without write enable");

  a_write_no_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |-> !frame_good && !frame_error)
    else $error("store write together with frame end");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(write_data) && $stable(frame_ready))
    else $error("stalled output changed");

endmodule

bind ubx_nav_frame_parser ubx_nav_checker u_ubx_nav_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .write_enable (write_enable),
  .write_offset (write_offset),
  .write_data   (write_data),
  .frame_good   (frame_good),
  .frame_error  (frame_error),
  .frame_ready  (frame_ready)
);
